### hdl/mgwm_pkg.sv
// Shared types and constants of the masked Gaussian weighted mean core.
`default_nettype none
package mgwm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 16;
    localparam int CIDX_BITS   = 11;
    localparam int WLEN_BITS   = 12;
    localparam int POS_BITS    = 32;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 12'd1200;

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_COEFF  = 1'b1
    } mgwm_action_t;

    typedef struct packed {
        mgwm_action_t                   action;
        logic signed [SAMPLE_BITS-1:0]  sample_value;
        logic [CIDX_BITS-1:0]           coeff_index;
        logic [COEFF_BITS-1:0]          coeff_value;
        logic                           end_of_sequence;
    } mgwm_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  smoothed_value;
        logic [POS_BITS-1:0]            center_position;
        logic                           final_of_sequence;
    } mgwm_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_HOLD
    } mgwm_state_t;

    // Control from the sequencer to the tap engine
    typedef struct packed {
        logic start;
        logic sample_we;
        logic coeff_we;
    } mgwm_ctl_t;

    // Status from the divider chain
    typedef struct packed {
        logic                           done;
        logic signed [SAMPLE_BITS-1:0]  value;
    } mgwm_div_res_t;

endpackage
`default_nettype wire

### hdl/masked_gaussian_weighted_mean_core.sv
// Top level of the masked Gaussian weighted mean core.
`default_nettype none
// Masked Gaussian weighted mean over a sliding window of window_len taps.
// Each item is either a coefficient load (written into the coefficient
// memory at coeff_index, ignored when the index is MAX_TAPS or more) or a
// signed Q4.11 sample. Samples equal to zero are missing and drop out of
// both the weighted sum and the weight sum. Once a sequence holds a full
// window, each sample yields the mean for the window center, truncated
// toward zero and saturated, or 0 when no weight remains; the sample
// carrying end_of_sequence restarts the window and, for an even window
// length, gives no result. A sample that gives a result holds item_ready
// low while the tap engine reads one sample and one coefficient per cycle
// from its two memories and runs one 16x17 multiply-accumulate per tap
// through its read, product and accumulator registers; then a chain of 16
// division cells resolves one quotient bit per cell after a prepare stage,
// and the word enters the output register. The next item is taken while
// that word still waits for result_ready. window_len is written through
// the cfg port (always ready); the user must write it only while the core
// is idle, as the core does not enforce this; 0 acts as 1 and values above
// MAX_TAPS act as MAX_TAPS. Neither memory is cleared at reset, so load
// every tap in use before streaming.
module masked_gaussian_weighted_mean_core
    import mgwm_pkg::*;
#(
    parameter int MAX_TAPS = 2048
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire mgwm_item_t           item,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output mgwm_result_t              result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [WLEN_BITS-1:0] cfg_data
);

    localparam int AW     = $clog2(MAX_TAPS);
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int WSUM_W = COEFF_BITS + AW;
    localparam int ACC_W  = SAMPLE_BITS + COEFF_BITS + AW;
    localparam logic [AW-1:0]       LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [POS_BITS-1:0] SEEN_MAX  = '1;

    mgwm_state_t             state_reg, state_next;
    logic [WLEN_BITS-1:0]    wlen_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [POS_BITS-1:0]     seen_reg, seen_next;
    logic [POS_BITS-1:0]     center_reg;
    logic                    final_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                    res_valid_reg, res_valid_next;
    mgwm_result_t            res_reg;

    logic                    accept, is_sample, is_coeff, last, produce, in_range;
    logic                    load_out;
    logic [31:0]             wl32, taps32, taps_m1, half32, base32;
    logic [POS_BITS-1:0]     center, lhs, rhs;
    logic [TW-1:0]           taps;
    logic [AW-1:0]           base;
    logic [31:0]             cidx32;

    mgwm_ctl_t               ctl;
    logic                    mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic [WSUM_W-1:0]       mac_wsum;
    mgwm_div_res_t           div_res;

    // Taps in use and window geometry
    always_comb
    begin
        wl32 = 32'(wlen_reg);
        if (wl32 == 32'd0)
        begin
            taps32 = 32'd1;
        end
        else if (wl32 > 32'(MAX_TAPS))
        begin
            taps32 = 32'(MAX_TAPS);
        end
        else
        begin
            taps32 = wl32;
        end
        taps    = TW'(taps32);
        taps_m1 = taps32 - 32'd1;
        half32  = taps32 >> 1;

        // Oldest slot of the window that the newest sample completes
        base32 = 32'(wp_reg) + 32'(MAX_TAPS) - taps_m1;
        if (base32 >= 32'(MAX_TAPS))
        begin
            base32 = base32 - 32'(MAX_TAPS);
        end
        base = AW'(base32);
    end

    // Decode the incoming word
    always_comb
    begin
        accept    = item_valid && item_ready;
        is_sample = accept && (item.action == ACT_SAMPLE);
        is_coeff  = accept && (item.action == ACT_COEFF);
        last      = item.end_of_sequence;
        cidx32    = 32'(item.coeff_index);

        center   = seen_reg - taps_m1 + half32;
        lhs      = center + half32 + 32'd1;
        rhs      = seen_reg + 32'd1;
        // The last sample of a sequence must not push the center past length-half-1
        in_range = !(last && (lhs > rhs));
        produce  = is_sample && (seen_reg >= taps_m1) && in_range;
    end

    // Advance the write pointer and sample count; restart on end of sequence
    always_comb
    begin
        wp_next   = wp_reg;
        seen_next = seen_reg;
        if (is_sample)
        begin
            if (last)
            begin
                wp_next   = '0;
                seen_next = '0;
            end
            else
            begin
                wp_next   = (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
                seen_next = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + 32'd1;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (produce)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        item_ready    = 1'b0;
        load_out      = 1'b0;
        ctl.start     = 1'b0;
        ctl.sample_we = 1'b0;
        ctl.coeff_we  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                ctl.start     = produce;
                ctl.sample_we = is_sample;
                ctl.coeff_we  = is_coeff && (cidx32 < 32'(MAX_TAPS));
            end
            ST_HOLD:
            begin
                load_out = !res_valid_reg || result_ready;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Output register: hold the word until taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    mgwm_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sample_addr (wp_reg),
        .sample_data (item.sample_value),
        .coeff_addr  (AW'(cidx32)),
        .coeff_data  (item.coeff_value),
        .base        (base),
        .taps        (taps),
        .done        (mac_done),
        .acc         (mac_acc),
        .wsum        (mac_wsum)
    );

    mgwm_divider #(
        .WSUM_W (WSUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_done),
        .acc   (mac_acc),
        .wsum  (mac_wsum),
        .res   (div_res)
    );

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            center_reg <= center;
            final_reg  <= last;
        end
        if (div_res.done)
        begin
            value_reg <= div_res.value;
        end
        if (load_out)
        begin
            res_reg.smoothed_value    <= value_reg;
            res_reg.center_position   <= center_reg;
            res_reg.final_of_sequence <= final_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= WLEN_RESET;
            wp_reg        <= '0;
            seen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            seen_reg      <= seen_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid)
            begin
                wlen_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

### hdl/mgwm_mac.sv
// Tap engine: sample and coefficient memories and the serial multiply-accumulate.
`default_nettype none
module mgwm_mac
    import mgwm_pkg::*;
#(
    parameter int MAX_TAPS = 2048
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire mgwm_ctl_t                                     ctl,
    input  wire logic [$clog2(MAX_TAPS)-1:0]                   sample_addr,
    input  wire logic signed [SAMPLE_BITS-1:0]                 sample_data,
    input  wire logic [$clog2(MAX_TAPS)-1:0]                   coeff_addr,
    input  wire logic [COEFF_BITS-1:0]                         coeff_data,
    input  wire logic [$clog2(MAX_TAPS)-1:0]                   base,
    input  wire logic [$clog2(MAX_TAPS+1)-1:0]                 taps,
    output logic                                               done,
    output logic signed [SAMPLE_BITS+COEFF_BITS+$clog2(MAX_TAPS)-1:0] acc,
    output logic [COEFF_BITS+$clog2(MAX_TAPS)-1:0]             wsum
);

    localparam int AW     = $clog2(MAX_TAPS);
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int WSUM_W = COEFF_BITS + AW;
    localparam int ACC_W  = SAMPLE_BITS + COEFF_BITS + AW;
    localparam int PROD_W = SAMPLE_BITS + COEFF_BITS + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    logic signed [SAMPLE_BITS-1:0] sample_mem [MAX_TAPS];
    logic [COEFF_BITS-1:0]         coeff_mem  [MAX_TAPS];

    logic                          issuing_reg, issuing_next;
    logic [TW-1:0]                 cnt_reg, cnt_next;
    logic [AW-1:0]                 saddr_reg, saddr_next;
    logic                          rd_v_reg, mul_v_reg, done_reg;
    logic signed [SAMPLE_BITS-1:0] rd_sample_reg;
    logic [COEFF_BITS-1:0]         rd_coeff_reg;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic [COEFF_BITS-1:0]         wadd_reg, wadd_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic [WSUM_W-1:0]             wsum_reg, wsum_next;
    logic                          last_issue;

    assign last_issue = (cnt_reg == TW'(taps - TW'(1)));

    always_comb
    begin
        issuing_next = issuing_reg;
        cnt_next     = cnt_reg;
        saddr_next   = saddr_reg;
        if (ctl.start)
        begin
            issuing_next = 1'b1;
            cnt_next     = '0;
            saddr_next   = base;
        end
        else if (issuing_reg)
        begin
            cnt_next   = cnt_reg + TW'(1);
            saddr_next = (saddr_reg == LAST_ADDR) ? '0 : saddr_reg + AW'(1);
            if (last_issue)
            begin
                issuing_next = 1'b0;
            end
        end
    end

    // Missing samples contribute neither product nor weight
    always_comb
    begin
        if (rd_sample_reg == '0)
        begin
            prod_next = '0;
            wadd_next = '0;
        end
        else
        begin
            prod_next = PROD_W'(rd_sample_reg * $signed({1'b0, rd_coeff_reg}));
            wadd_next = rd_coeff_reg;
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        wsum_next = wsum_reg;
        if (ctl.start)
        begin
            acc_next  = '0;
            wsum_next = '0;
        end
        else if (mul_v_reg)
        begin
            acc_next  = acc_reg + ACC_W'(prod_reg);
            wsum_next = wsum_reg + WSUM_W'(wadd_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sample_we)
        begin
            sample_mem[sample_addr] <= sample_data;
        end
        if (issuing_reg)
        begin
            rd_sample_reg <= sample_mem[saddr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.coeff_we)
        begin
            coeff_mem[coeff_addr] <= coeff_data;
        end
        if (issuing_reg)
        begin
            rd_coeff_reg <= coeff_mem[cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        saddr_reg <= saddr_next;
        prod_reg  <= prod_next;
        wadd_reg  <= wadd_next;
        acc_reg   <= acc_next;
        wsum_reg  <= wsum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
            mul_v_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            issuing_reg <= issuing_next;
            rd_v_reg    <= issuing_reg;
            mul_v_reg   <= rd_v_reg;
            done_reg    <= mul_v_reg && !rd_v_reg;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign wsum = wsum_reg;

endmodule
`default_nettype wire

### hdl/mgwm_div_cell.sv
// One restoring division cell: resolves one quotient bit and passes on.
`default_nettype none
module mgwm_div_cell
    import mgwm_pkg::*;
#(
    parameter int REM_W = 43
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [REM_W-1:0]       in_rem,
    input  wire logic [SAMPLE_BITS-1:0] in_quo,
    input  wire logic [REM_W-1:0]       divisor,
    output logic                        out_valid,
    output logic [REM_W-1:0]            out_rem,
    output logic [SAMPLE_BITS-1:0]      out_quo
);

    logic                   valid_reg;
    logic [REM_W-1:0]       rem_reg, rem_next, diff;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic                   ge;

    always_comb
    begin
        ge       = (in_rem >= divisor);
        diff     = ge ? (in_rem - divisor) : in_rem;
        rem_next = {diff[REM_W-2:0], 1'b0};
        quo_next = {in_quo[SAMPLE_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;

endmodule
`default_nettype wire

### hdl/mgwm_divider.sv
// Signed divide with saturation: a prepare stage and a chain of division cells.
`default_nettype none
module mgwm_divider
    import mgwm_pkg::*;
#(
    parameter int WSUM_W = 27
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [WSUM_W+SAMPLE_BITS-1:0]   acc,
    input  wire logic [WSUM_W-1:0]                      wsum,
    output mgwm_div_res_t                               res
);

    localparam int REM_W = WSUM_W + SAMPLE_BITS;
    localparam logic [SAMPLE_BITS-1:0] MAX_POS  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] MIN_NEG  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] HALF_MAG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                   pre_v_reg;
    logic                   neg_reg, sat_reg, zero_reg;
    logic [REM_W-1:0]       rem0_reg, div_reg;
    logic [REM_W-1:0]       mag;
    logic                   res_done_reg;
    logic [SAMPLE_BITS-1:0] res_val_reg, res_val_next;

    logic                   cv [SAMPLE_BITS+1];
    logic [REM_W-1:0]       cr [SAMPLE_BITS+1];
    logic [SAMPLE_BITS-1:0] cq [SAMPLE_BITS+1];
    logic [SAMPLE_BITS-1:0] q;

    assign mag = acc[REM_W-1] ? (~acc + REM_W'(1)) : acc;

    // Prepare: magnitude, sign, and the out-of-range test q >= 2^SAMPLE_BITS
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= acc[REM_W-1];
            zero_reg <= (wsum == '0);
            sat_reg  <= (mag >= {wsum, {SAMPLE_BITS{1'b0}}});
            rem0_reg <= mag;
            div_reg  <= REM_W'({wsum, {(SAMPLE_BITS-1){1'b0}}});
        end
    end

    assign cv[0] = pre_v_reg;
    assign cr[0] = rem0_reg;
    assign cq[0] = '0;

    for (genvar i = 0; i < SAMPLE_BITS; i++)
    begin : g_cell
        mgwm_div_cell #(
            .REM_W (REM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_rem    (cr[i]),
            .in_quo    (cq[i]),
            .divisor   (div_reg),
            .out_valid (cv[i+1]),
            .out_rem   (cr[i+1]),
            .out_quo   (cq[i+1])
        );
    end

    assign q = cq[SAMPLE_BITS];

    always_comb
    begin
        if (zero_reg)
        begin
            res_val_next = '0;
        end
        else if (neg_reg)
        begin
            res_val_next = (sat_reg || (q > HALF_MAG)) ? MIN_NEG : (~q + SAMPLE_BITS'(1));
        end
        else
        begin
            res_val_next = (sat_reg || q[SAMPLE_BITS-1]) ? MAX_POS : q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cv[SAMPLE_BITS])
        begin
            res_val_reg <= res_val_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_v_reg    <= 1'b0;
            res_done_reg <= 1'b0;
        end
        else
        begin
            pre_v_reg    <= start;
            res_done_reg <= cv[SAMPLE_BITS];
        end
    end

    assign res.done  = res_done_reg;
    assign res.value = res_val_reg;

endmodule
`default_nettype wire
